FILE: hw/rtl/sct_pkg.sv
package sct_pkg;

  localparam int MAX_COLUMNS_DEF = 16;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELD_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS        = 2'd2;

  localparam logic [4:0]  COLUMN_COUNT_RST    = 5'd5;
  localparam logic [23:0] MAX_FIELD_BYTES_RST = 24'd1048576;
  localparam logic [19:0] MAX_ROWS_RST        = 20'd100000;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_AFTER_CLOSE  = 4'd1,
    ERR_QUOTE        = 4'd2,
    ERR_FIELD_LIMIT  = 4'd3,
    ERR_ROW_SHAPE    = 4'd4,
    ERR_LINE_END     = 4'd5,
    ERR_UNTERMINATED = 4'd6,
    ERR_FINAL_ROW    = 4'd7,
    ERR_NO_ROWS      = 4'd8
  } err_t;

  typedef struct packed {
    logic [4:0]  column_count;
    logic [23:0] max_field_bytes;
    logic [19:0] max_rows;
  } cfg_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [3:0]  column_index;
    logic        field_done;
    logic        row_done;
    logic [19:0] row_index;
    err_t        err_code;
    logic        source_done;
  } res_t;

endpackage

FILE: hw/rtl/sct_if.sv
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source(output valid, output operation, output byte_value, input ready);
  modport sink(input valid, input operation, input byte_value, output ready);
endinterface

interface sct_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [3:0]  column_index;
  logic        field_done;
  logic        row_done;
  logic [19:0] row_index;
  logic [3:0]  err_code;
  logic        source_done;

  modport source(output valid, output data_valid, output data_byte, output column_index,
                 output field_done, output row_done, output row_index,
                 output err_code, output source_done, input ready);
  modport sink(input valid, input data_valid, input data_byte, input column_index,
               input field_done, input row_done, input row_index,
               input err_code, input source_done, output ready);
endinterface

FILE: hw/rtl/sct_cfg.sv
module sct_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [sct_pkg::CFG_IDX_W-1:0]      index,
  input  logic [sct_pkg::CFG_DATA_W-1:0]     data,
  output sct_pkg::cfg_t                      cfg
);
  import sct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_count    <= COLUMN_COUNT_RST;
      cfg.max_field_bytes <= MAX_FIELD_BYTES_RST;
      cfg.max_rows        <= MAX_ROWS_RST;
    end else if (wr_en) begin
      case (index)
        CFG_COLUMN_COUNT:    cfg.column_count    <= data[4:0];
        CFG_MAX_FIELD_BYTES: cfg.max_field_bytes <= data[23:0];
        CFG_MAX_ROWS:        cfg.max_rows        <= data[19:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sct_core.sv
module sct_core #(
  parameter int MAX_COLUMNS = sct_pkg::MAX_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sct_pkg::cfg_t  cfg,
  input  logic           step,
  input  logic           operation,
  input  logic [7:0]     byte_value,
  output sct_pkg::res_t  res,
  output logic           res_en
);
  import sct_pkg::*;

  // column_count is 5 bits, so the limit never exceeds 31
  localparam int LIM_CAP = (MAX_COLUMNS < 31) ? MAX_COLUMNS : 31;
  localparam int CW      = $clog2(LIM_CAP + 1);

  logic          in_quotes, quote_pending, quote_closed, cr_pending, field_nonempty;
  logic [CW-1:0] column_counter;
  logic [24:0]   field_length;
  logic [20:0]   row_counter;
  err_t          error_latched;

  logic          in_quotes_next, quote_pending_next, quote_closed_next;
  logic          cr_pending_next, field_nonempty_next;
  logic [CW-1:0] column_counter_next;
  logic [24:0]   field_length_next;
  logic [20:0]   row_counter_next;
  err_t          error_latched_next;

  logic [CW-1:0] lim;
  logic [CW:0]   col_inc;
  logic [24:0]   len_inc;
  logic [20:0]   row_inc;
  logic          field_ok, row_ok;
  logic          handled, qc_mid, eos_fd;
  err_t          fail_code, eos_err;

  assign lim = (int'(cfg.column_count) > LIM_CAP) ? CW'(LIM_CAP) : CW'(cfg.column_count);
  assign col_inc = {1'b0, column_counter} + 1'b1;
  assign len_inc = (field_length == '1) ? field_length : field_length + 1'b1;
  assign row_inc = (row_counter == '1) ? row_counter : row_counter + 1'b1;
  assign field_ok = (field_length <= {1'b0, cfg.max_field_bytes}) && (column_counter < lim);
  assign row_ok = field_ok && (col_inc == {1'b0, lim}) &&
                  (row_counter <= {1'b0, cfg.max_rows});

  always_comb begin
    in_quotes_next      = in_quotes;
    quote_pending_next  = quote_pending;
    quote_closed_next   = quote_closed;
    cr_pending_next     = cr_pending;
    field_nonempty_next = field_nonempty;
    column_counter_next = column_counter;
    field_length_next   = field_length;
    row_counter_next    = row_counter;
    error_latched_next  = error_latched;
    handled   = 1'b0;
    qc_mid    = quote_closed;
    eos_fd    = 1'b0;
    eos_err   = error_latched;
    fail_code = ERR_NONE;
    res_en    = 1'b0;
    res       = '0;
    res.column_index = (int'(column_counter) > 15) ? 4'd15 : 4'(column_counter);
    res.row_index    = row_counter[20] ? 20'hFFFFF : row_counter[19:0];
    res.err_code     = ERR_NONE;

    if (operation == OP_EOS) begin
      if (error_latched == ERR_NONE) begin
        if (cr_pending) begin
          eos_err = ERR_LINE_END;
        end else if (in_quotes && !quote_pending) begin
          eos_err = ERR_UNTERMINATED;
        end else if (column_counter != '0 || field_nonempty || quote_closed ||
                     quote_pending) begin
          if (row_ok) begin
            eos_fd = 1'b1;
          end else begin
            eos_err = ERR_FINAL_ROW;
          end
        end
        if (eos_err == ERR_NONE && row_counter == '0 && !eos_fd) begin
          eos_err = ERR_NO_ROWS;
        end
      end
      res_en          = 1'b1;
      res.source_done = 1'b1;
      res.field_done  = eos_fd;
      res.row_done    = eos_fd;
      res.err_code    = eos_err;
      in_quotes_next      = 1'b0;
      quote_pending_next  = 1'b0;
      quote_closed_next   = 1'b0;
      cr_pending_next     = 1'b0;
      field_nonempty_next = 1'b0;
      column_counter_next = '0;
      field_length_next   = '0;
      row_counter_next    = '0;
      error_latched_next  = ERR_NONE;
    end else if (error_latched == ERR_NONE) begin
      if (cr_pending && byte_value != CH_LF) begin
        fail_code = ERR_LINE_END;
      end else begin
        cr_pending_next = 1'b0;
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (byte_value == CH_QUOTE) begin
            handled = 1'b1;
            res_en  = 1'b1;
          end else begin
            in_quotes_next = 1'b0;
            qc_mid         = 1'b1;
          end
        end else if (in_quotes) begin
          handled = 1'b1;
          if (byte_value == CH_QUOTE) begin
            quote_pending_next = 1'b1;
          end else begin
            res_en = 1'b1;
          end
        end
        quote_closed_next = qc_mid;
        if (!handled) begin
          if (qc_mid && byte_value != CH_COMMA && byte_value != CH_CR &&
              byte_value != CH_LF) begin
            fail_code = ERR_AFTER_CLOSE;
          end else if (byte_value == CH_QUOTE) begin
            if (field_nonempty || qc_mid) begin
              fail_code = ERR_QUOTE;
            end else begin
              in_quotes_next = 1'b1;
            end
          end else if (byte_value == CH_COMMA) begin
            if (!field_ok) begin
              fail_code = ERR_FIELD_LIMIT;
            end else begin
              column_counter_next = col_inc[CW-1:0];
              field_length_next   = '0;
              field_nonempty_next = 1'b0;
              quote_closed_next   = 1'b0;
              res_en              = 1'b1;
              res.field_done      = 1'b1;
            end
          end else if (byte_value == CH_LF) begin
            if (!row_ok) begin
              fail_code = ERR_ROW_SHAPE;
            end else begin
              column_counter_next = '0;
              field_length_next   = '0;
              field_nonempty_next = 1'b0;
              quote_closed_next   = 1'b0;
              row_counter_next    = row_inc;
              res_en              = 1'b1;
              res.field_done      = 1'b1;
              res.row_done        = 1'b1;
            end
          end else if (byte_value == CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            res_en = 1'b1;
          end
        end
        // content byte: counts toward the field length
        if (res_en && !res.field_done) begin
          field_length_next   = len_inc;
          field_nonempty_next = 1'b1;
          res.data_valid      = 1'b1;
          res.data_byte       = byte_value;
        end
      end
      if (fail_code != ERR_NONE) begin
        // row check failed after the last field closed: that field still counts
        if (fail_code == ERR_ROW_SHAPE && field_ok) begin
          column_counter_next = col_inc[CW-1:0];
          res.column_index    = (int'(col_inc) > 15) ? 4'd15 : 4'(col_inc);
        end
        error_latched_next = fail_code;
        res_en             = 1'b1;
        res.data_valid     = 1'b0;
        res.data_byte      = '0;
        res.field_done     = 1'b0;
        res.row_done       = 1'b0;
        res.err_code       = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      quote_pending  <= 1'b0;
      quote_closed   <= 1'b0;
      cr_pending     <= 1'b0;
      field_nonempty <= 1'b0;
      column_counter <= '0;
      field_length   <= '0;
      row_counter    <= '0;
      error_latched  <= ERR_NONE;
    end else if (step) begin
      in_quotes      <= in_quotes_next;
      quote_pending  <= quote_pending_next;
      quote_closed   <= quote_closed_next;
      cr_pending     <= cr_pending_next;
      field_nonempty <= field_nonempty_next;
      column_counter <= column_counter_next;
      field_length   <= field_length_next;
      row_counter    <= row_counter_next;
      error_latched  <= error_latched_next;
    end
  end

  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> in_quotes)
    else $error("quote pending outside a quoted field");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    step && operation == OP_EOS |=> error_latched == ERR_NONE && row_counter == '0 &&
      column_counter == '0 && !in_quotes && !cr_pending)
    else $error("state not cleared after end of source");

  a_latched_silent: assert property (@(posedge clk) disable iff (rst)
    step && operation == OP_DATA && error_latched != ERR_NONE |-> !res_en)
    else $error("word produced after a latched error");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    res_en && res.data_valid |-> !res.field_done && res.err_code == ERR_NONE)
    else $error("content byte combined with field end or error");

endmodule

FILE: hw/rtl/strict_csv_tokenizer_top.sv
// Pipeline: a word is accepted into the input register, decoded combinationally from it and
// presented from the result register.
// Throughput: one word per cycle while the result is not stalled; the state update on the
// registered word sets the rate, and a stalled result holds the result and input registers.
// Reset (rst, synchronous, active high) clears all parse state and restores the
// configuration registers to column_count 5, max_field_bytes 1048576, max_rows 100000.
module strict_csv_tokenizer_top #(
  parameter int MAX_COLUMNS = sct_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  sct_in_if.sink                          item,
  sct_out_if.source                       result,
  input  logic                            cfg_wr_en,
  input  logic [sct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sct_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;
  res_t       step_res;
  logic       step_en;
  logic       out_valid;
  res_t       out_res;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  sct_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  sct_core #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .operation  (in_op),
    .byte_value (in_byte),
    .res        (step_res),
    .res_en     (step_en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= step_en;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_op   <= item.operation;
      in_byte <= item.byte_value;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.data_valid   = out_res.data_valid;
  assign result.data_byte    = out_res.data_byte;
  assign result.column_index = out_res.column_index;
  assign result.field_done   = out_res.field_done;
  assign result.row_done     = out_res.row_done;
  assign result.row_index    = out_res.row_index;
  assign result.err_code     = 4'(out_res.err_code);
  assign result.source_done  = out_res.source_done;

endmodule
